// ----- rtl/core/tdp_pkg.sv -----
`timescale 1ns / 1ps

package tdp_pkg;

    // default operand width
    localparam int VALUE_WIDTH_DEF = 32;

    // the only even prime, also the smallest prime
    localparam int SMALLEST_PRIME = 2;

    // odd trial divisors start here and advance by the step
    localparam int FIRST_DIVISOR = 3;
    localparam int DIVISOR_STEP  = 2;

endpackage

// ----- rtl/core/tdp_divider.sv -----
`timescale 1ns / 1ps

module tdp_divider #(
    parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_dividend,
    input  logic [VALUE_WIDTH-1:0] i_divisor,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_quotient,
    output logic [VALUE_WIDTH-1:0] o_remainder
);
    import tdp_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH);

    logic                   r_busy;
    logic                   n_busy;
    logic                   r_done;
    logic                   n_done;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic [VALUE_WIDTH-1:0] r_rem;
    logic [VALUE_WIDTH-1:0] n_rem;
    logic [VALUE_WIDTH-1:0] r_quo;
    logic [VALUE_WIDTH-1:0] n_quo;
    logic [VALUE_WIDTH-1:0] r_div;
    logic [VALUE_WIDTH-1:0] n_div;
    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   diff;
    logic                   fits;

    // one restoring step per cycle, msb first
    assign shifted = {r_rem, r_quo[VALUE_WIDTH-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = shifted >= {1'b0, r_div};

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_count = r_count;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_div   = r_div;
        if (r_busy) begin
            n_rem = fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
            n_quo = {r_quo[VALUE_WIDTH-2:0], fits};
            if (r_count == CW'(VALUE_WIDTH - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else if (i_start) begin
            n_busy  = 1'b1;
            n_count = '0;
            n_rem   = '0;
            n_quo   = i_dividend;
            n_div   = i_divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_busy  <= n_busy;
            r_done  <= n_done;
            r_count <= n_count;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    // the remainder never reaches the divisor once the pass is over
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < r_div))
        else $error("remainder not below divisor");

    // done only follows a busy pass
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a pass");

    // a start is never issued while a pass runs
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_start)
        else $error("start while busy");

endmodule

// ----- rtl/core/trial_division_prime_test.sv -----
`timescale 1ns / 1ps
// decision: negative, zero, one and even values go straight to the finish state; odd values of 3
//   or more run one pass of the one-bit-per-cycle divider per odd trial divisor
// trial divisors: odd, up to about sqrt(value), so about sqrt(value) / 2 of them, roughly 23000 for 31-bit primes
// throughput: one value at a time; the next beat is taken once the result is in the output reg
// reset: synchronous active low, returns to idle and drops the output valid

module trial_division_prime_test #(
    parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_is_prime
);
    import tdp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE      = 4'b0001,
        S_DIV_START = 4'b0010,
        S_DIV_WAIT  = 4'b0100,
        S_FINISH    = 4'b1000
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [VALUE_WIDTH-1:0] n_value;
    logic [VALUE_WIDTH-1:0] r_divisor;
    logic [VALUE_WIDTH-1:0] n_divisor;
    logic                   r_result;
    logic                   n_result;
    logic                   r_out_valid;
    logic                   n_out_valid;
    logic                   r_out_prime;
    logic                   n_out_prime;
    logic                   div_start;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quo;
    logic [VALUE_WIDTH-1:0] div_rem;
    logic [VALUE_WIDTH-1:0] in_bits;

    assign in_bits = $unsigned(i_value);

    tdp_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_value),
        .i_divisor   (r_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state     = r_state;
        n_value     = r_value;
        n_divisor   = r_divisor;
        n_result    = r_result;
        n_out_valid = r_out_valid;
        n_out_prime = r_out_prime;
        div_start   = 1'b0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_value   = in_bits;
                    n_divisor = VALUE_WIDTH'(FIRST_DIVISOR);
                    if (in_bits[VALUE_WIDTH-1]) begin
                        n_result = 1'b0;
                        n_state  = S_FINISH;
                    end else if (in_bits < VALUE_WIDTH'(SMALLEST_PRIME)) begin
                        n_result = 1'b0;
                        n_state  = S_FINISH;
                    end else if (!in_bits[0]) begin
                        n_result = (in_bits == VALUE_WIDTH'(SMALLEST_PRIME));
                        n_state  = S_FINISH;
                    end else begin
                        n_state = S_DIV_START;
                    end
                end
            end
            S_DIV_START: begin
                div_start = 1'b1;
                n_state   = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (div_done) begin
                    // divisor above value / divisor means its square passed the value
                    if (r_divisor > div_quo) begin
                        n_result = 1'b1;
                        n_state  = S_FINISH;
                    end else if (div_rem == '0) begin
                        n_result = 1'b0;
                        n_state  = S_FINISH;
                    end else begin
                        n_divisor = r_divisor + VALUE_WIDTH'(DIVISOR_STEP);
                        n_state   = S_DIV_START;
                    end
                end
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_value     <= n_value;
        r_divisor   <= n_divisor;
        r_result    <= n_result;
        r_out_prime <= n_out_prime;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_is_prime  = r_out_prime;

    // trial divisors stay odd
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_WAIT) |-> r_divisor[0])
        else $error("even trial divisor");

    // divider results only land while waiting for them
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider done outside wait");

    // negative values never come out prime
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_value[VALUE_WIDTH-1]) |-> !r_result)
        else $error("negative value marked prime");

    // an even value is prime only when it is two
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !r_value[0] && r_result)
            |-> (r_value == VALUE_WIDTH'(SMALLEST_PRIME)))
        else $error("even value other than two marked prime");

endmodule

// ----- dv/tb_trial_division_prime_test.sv -----
`timescale 1ns / 1ps

module tb_trial_division_prime_test;

    import tdp_pkg::*;

    localparam int VW             = VALUE_WIDTH_DEF;
    localparam int RESET_CYCLES   = 12;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_CYCLES   = 200;
    localparam int TIMEOUT_CYCLES = 6_000_000;
    localparam int MAX_REPORTS    = 10;

    typedef struct {
        logic signed [VW-1:0] value;
        bit                   is_prime;
    } t_prime_answer;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic signed [VW-1:0] in_value  = '0;
    logic                 out_ready = 1'b0;
    logic                 in_ready;
    logic                 out_valid;
    logic                 out_is_prime;

    t_prime_answer prime_answers_q[$];
    int            fail_count    = 0;
    int            report_count  = 0;
    bit            hold_request  = 1'b0;
    int            burst_left    = 0;

    trial_division_prime_test #(
        .VALUE_WIDTH(VW)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_value    (in_value),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_is_prime (out_is_prime)
    );

    always #6 clk = ~clk;

    function automatic bit calc_is_prime(input logic signed [VW-1:0] v);
        longint unsigned n;
        longint unsigned d;
        if (v < 0) return 1'b0;
        n = longint'(unsigned'(v));
        if (n < SMALLEST_PRIME) return 1'b0;
        if (n[0] == 1'b0) return n == SMALLEST_PRIME;
        // d <= n / d keeps the bound free of overflow
        for (d = FIRST_DIVISOR; d <= n / d; d += DIVISOR_STEP) begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // one beat; valid is left high so the caller decides on a gap
    task automatic send_value(input logic signed [VW-1:0] v);
        t_prime_answer a;
        in_valid <= 1'b1;
        in_value <= v;
        do @(posedge clk); while (!in_ready);
        a.value    = v;
        a.is_prime = calc_is_prime(v);
        prime_answers_q.push_back(a);
    endtask

    // bursts of random length, random idle gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 12);
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic test_edge_values();
        logic signed [VW-1:0] vals[$];
        vals = '{32'sh8000_0000, -7, -2, -1, 0, 1, 2, 3, 4, 5, 9, 15, 25, 49,
                 63001, 65521, 196563, 1000003,
                 32'sh7FFF_FFFD, 32'sh7FFF_FFFE, 32'sh7FFF_FFFF};
        foreach (vals[i]) begin
            send_value(vals[i]);
            pace_sender();
        end
        in_valid <= 1'b0;
    endtask

    // long receiver hold while beats keep coming, so the input stalls
    task automatic test_output_backpressure();
        hold_request = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_value($urandom_range(0, 255));
        end
        in_valid <= 1'b0;
    endtask

    task automatic test_random_mix(input int count);
        logic signed [VW-1:0] v;
        int unsigned          k;
        int unsigned          sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 40) begin
                v = $urandom_range(0, 4095);
            end else if (sel < 60) begin
                v = $urandom_range(0, 65535);
            end else if (sel < 65) begin
                v = $urandom_range(0, 1 << 20);
            end else if (sel < 80) begin
                v = {1'b1, 31'($urandom)};
            end else if (sel < 90) begin
                v = {1'b0, 30'($urandom), 1'b0};
            end else begin
                // large value with a small odd factor, cheap to reject
                k = 2 * $urandom_range(1, 7) + 1;
                v = k * $urandom_range(1, 32'h7FFF_FFFF / k);
            end
            send_value(v);
            pace_sender();
        end
        in_valid <= 1'b0;
    endtask

    // result side: stretches of always ready, random stalls, slow pattern
    initial begin : result_sink
        int mode;
        int stretch;
        int held;
        mode    = 0;
        stretch = 0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD; held++) @(posedge clk);
            end
            if (stretch == 0) begin
                mode    = $urandom_range(0, 2);
                stretch = $urandom_range(20, 200);
            end
            stretch--;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                default: out_ready <= (stretch % 4 == 0);
            endcase
        end
    end

    always @(posedge clk) begin
        t_prime_answer a;
        if (rst_n && out_valid && out_ready) begin
            if (prime_answers_q.size() == 0) begin
                fail_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("unexpected result beat: is_prime=%0b", out_is_prime);
                end
            end else begin
                a = prime_answers_q.pop_front();
                if (out_is_prime !== a.is_prime) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("mismatch for value %0d: expected is_prime=%0b, got %0b",
                                 a.value, a.is_prime, out_is_prime);
                    end
                end
            end
        end
    end

    initial begin
        repeat (TIMEOUT_CYCLES) @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edge_values();
        test_output_backpressure();
        test_random_mix(72);
        while (prime_answers_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
